/* rtl/core/assert_macros.svh */
// assertion macros shared by the vertex transform rtl
// expects clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds whenever the antecedent holds in the same cycle
`define PVAT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the antecedent
`define PVAT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pvat_pkg.sv */
// shared widths, codes, types and helper functions of the vertex transform
// no dependencies
package pvat_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int TRIG_FRAC_BITS  = 14;

    localparam int COORD_W    = 24;
    localparam int PIV_W      = 16;
    localparam int FACT_W     = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int PIVC_W = PIV_W + COORD_FRAC_BITS;
    localparam int DIFF_W = ((PIVC_W > COORD_W) ? PIVC_W : COORD_W) + 1;
    localparam int DIR_W  = COORD_W + 1;
    localparam int PROD_W = FACT_W + DIFF_W;
    localparam int RES_W  = PROD_W + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REFLECT_X = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REFLECT_Y = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SWAP      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SWAP_NEG  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROTATE    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd6;

    localparam logic signed [FACT_W-1:0] SCALE_RESET = 16'sd1;
    localparam logic signed [FACT_W-1:0] COS_RESET   = 16'sd16384;

    localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((1 << COORD_FRAC_BITS) - 1);
    localparam logic signed [COORD_W:0] PIV_HI = (COORD_W + 1)'(32767);
    localparam logic signed [COORD_W:0] PIV_LO = (COORD_W + 1)'(-32768);
    localparam logic signed [COORD_W-1:0] OUT_MAX = COORD_W'(8388607);
    localparam logic signed [COORD_W-1:0] OUT_MIN = COORD_W'(-8388608);
    localparam logic signed [RES_W-1:0] RES_HI = RES_W'(8388607);
    localparam logic signed [RES_W-1:0] RES_LO = RES_W'(-8388608);
    localparam logic signed [RES_W-1:0] ROUND_HALF = RES_W'(1 << (TRIG_FRAC_BITS - 1));

    typedef enum logic [2:0] {
        OP_SCALE,
        OP_REFLECT_X,
        OP_REFLECT_Y,
        OP_SWAP,
        OP_SWAP_NEG,
        OP_ROTATE,
        OP_TRANSLATE,
        OP_PASS
    } op_t;

    typedef struct packed {
        logic signed [FACT_W-1:0]  scale_x;
        logic signed [FACT_W-1:0]  scale_y;
        logic signed [FACT_W-1:0]  cos_value;
        logic signed [FACT_W-1:0]  sin_value;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
    } cfg_t;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [PIV_W-1:0]   piv_x;
        logic signed [PIV_W-1:0]   piv_y;
        logic                      last;
    } entry_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] value;
        logic                      clipped;
    } clip_t;

    // integer part truncated toward zero, limited to the pivot range
    function automatic logic signed [PIV_W-1:0] pivot_of(input logic signed [COORD_W-1:0] c);
        logic signed [COORD_W:0] q;
        q = (COORD_W + 1)'(c >>> COORD_FRAC_BITS);
        if (c[COORD_W-1] && ((c & FRAC_MASK) != '0))
        begin
            q = q + (COORD_W + 1)'(1);
        end
        if (q > PIV_HI)
        begin
            return PIV_W'(PIV_HI);
        end
        if (q < PIV_LO)
        begin
            return PIV_W'(PIV_LO);
        end
        return q[PIV_W-1:0];
    endfunction

    function automatic clip_t clip(input logic signed [RES_W-1:0] v);
        clip_t r;
        if (v > RES_HI)
        begin
            r.value   = OUT_MAX;
            r.clipped = 1'b1;
        end
        else if (v < RES_LO)
        begin
            r.value   = OUT_MIN;
            r.clipped = 1'b1;
        end
        else
        begin
            r.value   = v[COORD_W-1:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/core/pvat_front.sv */
// front end: takes vertex transfers, tracks the pivot and decodes the mode
// depends on pvat_pkg and assert_macros.svh
module pvat_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [pvat_pkg::MODE_W-1:0]          mode,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pvat_pkg::COORD_W-1:0]  x_in,
    input  logic signed [pvat_pkg::COORD_W-1:0]  y_in,
    input  logic                                 first_vertex,
    input  logic                                 last_vertex,
    input  logic                                 q_full,
    output logic                                 push,
    output pvat_pkg::entry_t                     entry
);
    import pvat_pkg::*;

    `include "assert_macros.svh"

    logic signed [PIV_W-1:0] pivot_x_reg;
    logic signed [PIV_W-1:0] pivot_y_reg;
    logic signed [PIV_W-1:0] pivot_x_next;
    logic signed [PIV_W-1:0] pivot_y_next;
    op_t                     op;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        pivot_x_next = pivot_x_reg;
        pivot_y_next = pivot_y_reg;
        if (first_vertex)
        begin
            pivot_x_next = pivot_of(x_in);
            pivot_y_next = pivot_of(y_in);
        end
    end

    always_comb
    begin
        unique case (mode)
            MODE_SCALE:     op = OP_SCALE;
            MODE_REFLECT_X: op = OP_REFLECT_X;
            MODE_REFLECT_Y: op = OP_REFLECT_Y;
            MODE_SWAP:      op = OP_SWAP;
            MODE_SWAP_NEG:  op = OP_SWAP_NEG;
            MODE_ROTATE:    op = OP_ROTATE;
            MODE_TRANSLATE: op = OP_TRANSLATE;
            default:        op = OP_PASS;
        endcase
    end

    always_comb
    begin
        entry.op    = op;
        entry.x     = x_in;
        entry.y     = y_in;
        entry.dx    = DIFF_W'(x_in) - (DIFF_W'(pivot_x_next) <<< COORD_FRAC_BITS);
        entry.dy    = DIFF_W'(y_in) - (DIFF_W'(pivot_y_next) <<< COORD_FRAC_BITS);
        entry.piv_x = pivot_x_next;
        entry.piv_y = pivot_y_next;
        entry.last  = last_vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
        end
        else if (push)
        begin
            pivot_x_reg <= pivot_x_next;
            pivot_y_reg <= pivot_y_next;
        end
    end

    `PVAT_NEXT(a_pivot_capture, push && first_vertex,
        pivot_x_reg == $past(pivot_of(x_in)) && pivot_y_reg == $past(pivot_of(y_in)),
        "pivot not captured on first vertex")

endmodule

/* rtl/core/pvat_queue.sv */
// short queue of decoded vertices between front and back
// depends on pvat_pkg and assert_macros.svh
module pvat_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pvat_pkg::entry_t entry_in,
    output logic             full,
    output logic             valid,
    output pvat_pkg::entry_t head,
    input  logic             pop
);
    import pvat_pkg::*;

    `include "assert_macros.svh"

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PVAT_NEXT(a_push_grows, push && !pop,
        count_reg == $past(count_reg) + QCNT_W'(1), "queue count lost a push")

    `PVAT_IMPLY(a_no_overflow, full, !push, "push into full queue")

endmodule

/* rtl/core/pvat_back.sv */
// back end: multiply stage, then round, pivot add and clamp into the output register
// depends on pvat_pkg and assert_macros.svh
module pvat_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pvat_pkg::cfg_t                       cfg,
    input  logic                                 q_valid,
    input  pvat_pkg::entry_t                     head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pvat_pkg::COORD_W-1:0]  x_out,
    output logic signed [pvat_pkg::COORD_W-1:0]  y_out,
    output logic                                 last_out,
    output logic                                 saturated
);
    import pvat_pkg::*;

    `include "assert_macros.svh"

    typedef struct packed {
        op_t                       op;
        logic signed [PROD_W-1:0]  ax;
        logic signed [PROD_W-1:0]  bx;
        logic signed [PROD_W-1:0]  ay;
        logic signed [PROD_W-1:0]  by;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [PIV_W-1:0]   piv_x;
        logic signed [PIV_W-1:0]   piv_y;
        logic                      last;
    } stage_t;

    stage_t                    s1_reg;
    stage_t                    s1_next;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [COORD_W-1:0] x_out_reg;
    logic signed [COORD_W-1:0] y_out_reg;
    logic                      last_reg;
    logic                      sat_reg;
    logic                      out_adv;
    logic                      s1_adv;
    logic signed [FACT_W-1:0]  mx;
    logic signed [FACT_W-1:0]  my;
    logic signed [RES_W-1:0]   px;
    logic signed [RES_W-1:0]   py;
    logic signed [RES_W-1:0]   rx;
    logic signed [RES_W-1:0]   ry;
    clip_t                     clip_x;
    clip_t                     clip_y;

    assign out_adv        = !out_valid_reg || !out_stall;
    assign s1_adv         = !s1_valid_reg || out_adv;
    assign pop            = q_valid && s1_adv;
    assign s1_valid_next  = s1_adv ? q_valid : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    // multiply stage
    always_comb
    begin
        mx = (head.op == OP_ROTATE) ? cfg.cos_value : cfg.scale_x;
        my = (head.op == OP_ROTATE) ? cfg.cos_value : cfg.scale_y;
        s1_next.op    = head.op;
        s1_next.ax    = mx * head.dx;
        s1_next.bx    = cfg.sin_value * head.dy;
        s1_next.ay    = my * head.dy;
        s1_next.by    = cfg.sin_value * head.dx;
        s1_next.piv_x = head.piv_x;
        s1_next.piv_y = head.piv_y;
        s1_next.last  = head.last;
        unique case (head.op)
            OP_REFLECT_X:
            begin
                s1_next.dir_x = DIR_W'(head.x);
                s1_next.dir_y = -DIR_W'(head.y);
            end
            OP_REFLECT_Y:
            begin
                s1_next.dir_x = -DIR_W'(head.x);
                s1_next.dir_y = DIR_W'(head.y);
            end
            OP_SWAP:
            begin
                s1_next.dir_x = DIR_W'(head.y);
                s1_next.dir_y = DIR_W'(head.x);
            end
            OP_SWAP_NEG:
            begin
                s1_next.dir_x = -DIR_W'(head.y);
                s1_next.dir_y = -DIR_W'(head.x);
            end
            OP_TRANSLATE:
            begin
                s1_next.dir_x = DIR_W'(head.x) + DIR_W'(cfg.shift_x);
                s1_next.dir_y = DIR_W'(head.y) + DIR_W'(cfg.shift_y);
            end
            OP_SCALE, OP_ROTATE, OP_PASS:
            begin
                s1_next.dir_x = DIR_W'(head.x);
                s1_next.dir_y = DIR_W'(head.y);
            end
        endcase
    end

    // round (rotate only), add pivot (scale and rotate), clamp
    always_comb
    begin
        px = RES_W'(s1_reg.piv_x) <<< COORD_FRAC_BITS;
        py = RES_W'(s1_reg.piv_y) <<< COORD_FRAC_BITS;
        unique case (s1_reg.op)
            OP_SCALE:
            begin
                rx = px + RES_W'(s1_reg.ax);
                ry = py + RES_W'(s1_reg.ay);
            end
            OP_ROTATE:
            begin
                rx = px + ((RES_W'(s1_reg.ax) + RES_W'(s1_reg.bx) + ROUND_HALF)
                           >>> TRIG_FRAC_BITS);
                ry = py + ((RES_W'(s1_reg.ay) - RES_W'(s1_reg.by) + ROUND_HALF)
                           >>> TRIG_FRAC_BITS);
            end
            OP_REFLECT_X, OP_REFLECT_Y, OP_SWAP, OP_SWAP_NEG, OP_TRANSLATE, OP_PASS:
            begin
                rx = RES_W'(s1_reg.dir_x);
                ry = RES_W'(s1_reg.dir_y);
            end
        endcase
        clip_x = clip(rx);
        clip_y = clip(ry);
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_reg <= s1_next;
        end
        if (out_adv)
        begin
            x_out_reg <= clip_x.value;
            y_out_reg <= clip_y.value;
            last_reg  <= s1_reg.last;
            sat_reg   <= clip_x.clipped | clip_y.clipped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;
    assign last_out  = last_reg;
    assign saturated = sat_reg;

    `PVAT_IMPLY(a_sat_at_limit, out_valid_reg && sat_reg,
        x_out_reg == OUT_MAX || x_out_reg == OUT_MIN || y_out_reg == OUT_MAX || y_out_reg == OUT_MIN,
        "saturated flag without clipped coordinate")

    `PVAT_NEXT(a_stall_holds_pipe, s1_valid_reg && out_valid_reg && out_stall,
        s1_valid_reg && out_valid_reg, "pipeline dropped a vertex under stall")

endmodule

/* rtl/core/polygon_vertex_affine_transform.sv */
// top level of the polygon vertex affine transform: config registers and wiring
// depends on pvat_pkg, pvat_front, pvat_queue, pvat_back
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | x_in, y_in, first_vertex, last_vertex
//  out      | out_valid / out_stall| x_out, y_out, last_out, saturated
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// one vertex per cycle sustained while out_stall is low; each input transfer
// passes a queue slot, the multiply stage and round/clamp into the output register
// the four-entry queue stalls the input only when full; the output register
// holds a result under out_stall while earlier stages keep filling
// reset clears pivot, queue and valid state; config returns to identity scale
module polygon_vertex_affine_transform (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [pvat_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pvat_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pvat_pkg::COORD_W-1:0]    x_in,
    input  logic signed [pvat_pkg::COORD_W-1:0]    y_in,
    input  logic                                   first_vertex,
    input  logic                                   last_vertex,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pvat_pkg::COORD_W-1:0]    x_out,
    output logic signed [pvat_pkg::COORD_W-1:0]    y_out,
    output logic                                   last_out,
    output logic                                   saturated
);
    import pvat_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    entry_t            entry;
    entry_t            head;

    always_comb
    begin
        mode_next = mode_reg;
        cfg_next  = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODE:    mode_next         = cfg_data[MODE_W-1:0];
                CFG_SCALE_X: cfg_next.scale_x   = cfg_data[FACT_W-1:0];
                CFG_SCALE_Y: cfg_next.scale_y   = cfg_data[FACT_W-1:0];
                CFG_COS:     cfg_next.cos_value = cfg_data[FACT_W-1:0];
                CFG_SIN:     cfg_next.sin_value = cfg_data[FACT_W-1:0];
                CFG_SHIFT_X: cfg_next.shift_x   = cfg_data[COORD_W-1:0];
                CFG_SHIFT_Y: cfg_next.shift_y   = cfg_data[COORD_W-1:0];
                default:     mode_next         = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_SCALE;
            cfg_reg.scale_x   <= SCALE_RESET;
            cfg_reg.scale_y   <= SCALE_RESET;
            cfg_reg.cos_value <= COS_RESET;
            cfg_reg.sin_value <= '0;
            cfg_reg.shift_x   <= '0;
            cfg_reg.shift_y   <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            cfg_reg  <= cfg_next;
        end
    end

    pvat_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_in         (x_in),
        .y_in         (y_in),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .q_full       (q_full),
        .push         (push),
        .entry        (entry)
    );

    pvat_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .entry_in (entry),
        .full     (q_full),
        .valid    (q_valid),
        .head     (head),
        .pop      (pop)
    );

    pvat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_out     (x_out),
        .y_out     (y_out),
        .last_out  (last_out),
        .saturated (saturated)
    );

endmodule

/* dv/pvat_vertex_checker.sv */
// predicts every transformed vertex of polygon_vertex_affine_transform and checks the results
// watches the config port and both channels; depends on pvat_pkg only
module pvat_vertex_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [pvat_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pvat_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [pvat_pkg::COORD_W-1:0]    x_in,
    input  logic signed [pvat_pkg::COORD_W-1:0]    y_in,
    input  logic                                   first_vertex,
    input  logic                                   last_vertex,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [pvat_pkg::COORD_W-1:0]    x_out,
    input  logic signed [pvat_pkg::COORD_W-1:0]    y_out,
    input  logic                                   last_out,
    input  logic                                   saturated,
    output int                                     fail_count,
    output int                                     pending
);
    import pvat_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      sat;
    } vertex_t;

    localparam int     MAX_REPORTS = 10;
    localparam longint COORD_ONE   = longint'(1) << COORD_FRAC_BITS;
    localparam longint TRIG_HALF   = longint'(1) << (TRIG_FRAC_BITS - 1);
    localparam longint COORD_HI    = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_LO    = -(longint'(1) << (COORD_W - 1));
    localparam longint PIVOT_HI    = (longint'(1) << (PIV_W - 1)) - 1;
    localparam longint PIVOT_LO    = -(longint'(1) << (PIV_W - 1));

    logic [MODE_W-1:0]         mode_reg;
    logic signed [FACT_W-1:0]  scale_x_reg;
    logic signed [FACT_W-1:0]  scale_y_reg;
    logic signed [FACT_W-1:0]  cos_reg;
    logic signed [FACT_W-1:0]  sin_reg;
    logic signed [COORD_W-1:0] shift_x_reg;
    logic signed [COORD_W-1:0] shift_y_reg;
    logic signed [PIV_W-1:0]   pivot_x;
    logic signed [PIV_W-1:0]   pivot_y;
    vertex_t                   expected_vertices[$];
    vertex_t                   got;
    vertex_t                   want;
    int                        errors;

    function automatic longint clip_to(input longint v, input longint lo, input longint hi,
                                       inout logic hit);
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // integer part, truncated toward zero
    function automatic logic signed [PIV_W-1:0] pivot_part(input logic signed [COORD_W-1:0] c);
        logic ignored;
        ignored = 1'b0;
        return PIV_W'(clip_to(longint'(c) / COORD_ONE, PIVOT_LO, PIVOT_HI, ignored));
    endfunction

    function automatic vertex_t transform_vertex(input logic signed [COORD_W-1:0] xv,
                                                 input logic signed [COORD_W-1:0] yv,
                                                 input logic lastv);
        longint  xi;
        longint  yi;
        longint  px;
        longint  py;
        longint  dx;
        longint  dy;
        longint  rx;
        longint  ry;
        logic    hit;
        vertex_t r;
        xi = longint'(xv);
        yi = longint'(yv);
        px = longint'(pivot_x) * COORD_ONE;
        py = longint'(pivot_y) * COORD_ONE;
        dx = xi - px;
        dy = yi - py;
        case (mode_reg)
            MODE_SCALE:
            begin
                rx = px + longint'(scale_x_reg) * dx;
                ry = py + longint'(scale_y_reg) * dy;
            end
            MODE_REFLECT_X:
            begin
                rx = xi;
                ry = -yi;
            end
            MODE_REFLECT_Y:
            begin
                rx = -xi;
                ry = yi;
            end
            MODE_SWAP:
            begin
                rx = yi;
                ry = xi;
            end
            MODE_SWAP_NEG:
            begin
                rx = -yi;
                ry = -xi;
            end
            MODE_ROTATE:
            begin
                // round to nearest, ties toward plus infinity
                rx = px + ((longint'(cos_reg) * dx + longint'(sin_reg) * dy + TRIG_HALF)
                           >>> TRIG_FRAC_BITS);
                ry = py + ((longint'(cos_reg) * dy - longint'(sin_reg) * dx + TRIG_HALF)
                           >>> TRIG_FRAC_BITS);
            end
            MODE_TRANSLATE:
            begin
                rx = xi + longint'(shift_x_reg);
                ry = yi + longint'(shift_y_reg);
            end
            default:
            begin
                rx = xi;
                ry = yi;
            end
        endcase
        hit = 1'b0;
        r.x = COORD_W'(clip_to(rx, COORD_LO, COORD_HI, hit));
        r.y = COORD_W'(clip_to(ry, COORD_LO, COORD_HI, hit));
        r.last = lastv;
        r.sat = hit;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg = MODE_SCALE;
            scale_x_reg = SCALE_RESET;
            scale_y_reg = SCALE_RESET;
            cos_reg = COS_RESET;
            sin_reg = '0;
            shift_x_reg = '0;
            shift_y_reg = '0;
            pivot_x = '0;
            pivot_y = '0;
            expected_vertices.delete();
            errors = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MODE:    mode_reg = cfg_data[MODE_W-1:0];
                    CFG_SCALE_X: scale_x_reg = cfg_data[FACT_W-1:0];
                    CFG_SCALE_Y: scale_y_reg = cfg_data[FACT_W-1:0];
                    CFG_COS:     cos_reg = cfg_data[FACT_W-1:0];
                    CFG_SIN:     sin_reg = cfg_data[FACT_W-1:0];
                    CFG_SHIFT_X: shift_x_reg = cfg_data[COORD_W-1:0];
                    CFG_SHIFT_Y: shift_y_reg = cfg_data[COORD_W-1:0];
                    default:     ;
                endcase
            end
            // results first so a vertex accepted this edge is never matched at once
            if (out_valid && !out_stall)
            begin
                got.x = x_out;
                got.y = y_out;
                got.last = last_out;
                got.sat = saturated;
                if (expected_vertices.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("unexpected result transfer: x=%0d y=%0d last=%0b sat=%0b",
                                 got.x, got.y, got.last, got.sat);
                    end
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("vertex mismatch: expected x=%0d y=%0d last=%0b sat=%0b",
                                     want.x, want.y, want.last, want.sat);
                            $display("                 actual   x=%0d y=%0d last=%0b sat=%0b",
                                     got.x, got.y, got.last, got.sat);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (first_vertex)
                begin
                    pivot_x = pivot_part(x_in);
                    pivot_y = pivot_part(y_in);
                end
                expected_vertices.push_back(transform_vertex(x_in, y_in, last_vertex));
            end
            pending <= expected_vertices.size();
            fail_count <= errors;
        end
    end

endmodule

/* dv/polygon_vertex_affine_transform_tb.sv */
// top of the vertex transform testbench: clock, reset, config writes, vertex and stall traffic
// depends on pvat_pkg, polygon_vertex_affine_transform and pvat_vertex_checker
module polygon_vertex_affine_transform_tb;
    import pvat_pkg::*;

    localparam int NUM_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 53;
    localparam int NUM_OPS         = 8;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD       = 80;
    localparam int QUIET_LIMIT     = 2000;
    localparam int BIAS_NONE       = 0;
    localparam int BIAS_LOW        = 1;
    localparam int BIAS_HIGH       = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(CFG_SHIFT_Y + 3'd1);

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic                      first_vertex;
    logic                      last_vertex;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      last_out;
    logic                      saturated;
    int                        fail_count;
    int                        pending;
    int                        quiet_cycles;
    int                        hold_requests;
    logic                      calm;

    polygon_vertex_affine_transform u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_in         (x_in),
        .y_in         (y_in),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .x_out        (x_out),
        .y_out        (y_out),
        .last_out     (last_out),
        .saturated    (saturated)
    );

    pvat_vertex_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_in         (x_in),
        .y_in         (y_in),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .x_out        (x_out),
        .y_out        (y_out),
        .last_out     (last_out),
        .saturated    (saturated),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short idle stretches, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return OUT_MIN;
        end
        if (r == 1)
        begin
            return OUT_MAX;
        end
        if (r == 2)
        begin
            return '0;
        end
        if (r == 3)
        begin
            return '1;
        end
        if (r < 12)
        begin
            return COORD_W'(int'($urandom_range(0, 131071)) - 65536);
        end
        return COORD_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_value(input int bias, input int lo,
                                                         input int hi, input int near);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (bias == BIAS_LOW)
        begin
            v = lo;
        end
        else if (bias == BIAS_HIGH)
        begin
            v = hi;
        end
        else if (r == 0)
        begin
            v = lo;
        end
        else if (r == 1)
        begin
            v = hi;
        end
        else if (r == 2)
        begin
            v = 0;
        end
        else if (r < 7)
        begin
            v = int'($urandom_range(0, 2 * near)) - near;
        end
        else
        begin
            v = lo + int'($urandom_range(0, hi - lo));
        end
        return CFG_DATA_W'(v);
    endfunction

    // leaves cfg_write high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_vertex(input logic signed [COORD_W-1:0] xv,
                               input logic signed [COORD_W-1:0] yv,
                               input logic f, input logic l);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_in <= xv;
        y_in <= yv;
        first_vertex <= f;
        last_vertex <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input op_t op, input int bias);
        settle();
        write_reg(CFG_MODE, CFG_DATA_W'(op));
        write_reg(CFG_SCALE_X, pick_value(bias, -32768, 32767, 6));
        write_reg(CFG_SCALE_Y, pick_value(bias, -32768, 32767, 6));
        write_reg(CFG_COS, pick_value(bias, -16384, 16384, 16384));
        write_reg(CFG_SIN, pick_value(bias, -16384, 16384, 16384));
        write_reg(CFG_SHIFT_X, pick_value(bias, -8388608, 8388607, 4096));
        write_reg(CFG_SHIFT_Y, pick_value(bias, -8388608, 8388607, 4096));
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
    endtask

    // vertices cluster around a base point so scale and rotate stay mostly in range
    task automatic send_polygon(inout int count);
        int                        n;
        logic                      noisy;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic                      f;
        logic                      l;
        n = $urandom_range(1, 6);
        noisy = ($urandom_range(0, 9) == 0);
        bx = random_coord();
        by = random_coord();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                vx = random_coord();
                vy = random_coord();
            end
            else
            begin
                vx = bx + COORD_W'(int'($urandom_range(0, 4095)) - 2048);
                vy = by + COORD_W'(int'($urandom_range(0, 4095)) - 2048);
            end
            f = noisy ? 1'($urandom_range(0, 1)) : (i == 0);
            l = noisy ? 1'($urandom_range(0, 1)) : (i == n - 1);
            send_vertex(vx, vy, f, l);
            count++;
        end
    endtask

    // receiver: random stall runs, plus a long hold-off on request
    initial
    begin
        int   run_left;
        int   hold_left;
        int   holds_served;
        logic stall_now;
        run_left = 0;
        hold_left = 0;
        holds_served = 0;
        stall_now = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (holds_served < hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if (calm)
                    begin
                        stall_now = 1'b0;
                        run_left = 8;
                    end
                    else
                    begin
                        stall_now = ($urandom_range(0, 3) == 0);
                        run_left = stall_now ? idle_length() : $urandom_range(1, 10);
                    end
                end
                run_left--;
                out_stall <= stall_now;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        op_t op;
        int  bias;
        int  phase_items;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        x_in = '0;
        y_in = '0;
        first_vertex = 1'b0;
        last_vertex = 1'b0;
        hold_requests = 0;
        calm = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset pivot, then a capture with a negative fractional part
        send_vertex(-24'sh000180, 24'sh00017f, 1'b0, 1'b0);
        send_vertex(-24'sh000180, 24'sh000280, 1'b1, 1'b0);
        send_vertex(OUT_MAX, OUT_MIN, 1'b0, 1'b1);
        send_vertex(OUT_MIN, OUT_MAX, 1'b1, 1'b1);
        // every other operation, undefined mode included, with the coordinate extremes
        op = OP_REFLECT_X;
        repeat (NUM_OPS - 1)
        begin
            settle();
            write_reg(CFG_MODE, CFG_DATA_W'(op));
            cfg_write <= 1'b0;
            send_vertex(OUT_MIN, OUT_MAX, 1'b1, 1'b0);
            send_vertex(OUT_MAX, OUT_MIN, 1'b0, 1'b0);
            send_vertex(24'sh123456, -24'sh054321, 1'b0, 1'b1);
            op = op.next();
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0 || p == 5 || p == 6)
            begin
                bias = BIAS_LOW;
            end
            else if (p == 8 || p == 13 || p == 14)
            begin
                bias = BIAS_HIGH;
            end
            else
            begin
                bias = BIAS_NONE;
            end
            configure(op_t'(p % NUM_OPS), bias);
            calm = ($urandom_range(0, 3) == 0);
            if (p == 3 || p == 11)
            begin
                hold_requests++;
            end
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                send_polygon(phase_items);
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pvat_pkg.sv
rtl/core/pvat_front.sv
rtl/core/pvat_queue.sv
rtl/core/pvat_back.sv
rtl/core/polygon_vertex_affine_transform.sv
dv/pvat_vertex_checker.sv
dv/polygon_vertex_affine_transform_tb.sv
